FILE: sv/gni_pkg.sv
// ----------------------------------------------------------------------------
// gni_pkg
// Shared constants, register indexes and types of the grid neighbour indexer.
// ----------------------------------------------------------------------------
package gni_pkg;

	// field widths
	localparam int LON_W   = 29;   // lon_micro
	localparam int LAT_W   = 28;   // lat_micro
	localparam int OLON_W  = 19;   // cell_lon, lon_origin
	localparam int OLAT_W  = 18;   // cell_lat, lat_origin
	localparam int CELLS_W = 16;   // lon_cells, lat_cells
	localparam int BL_W    = 13;   // border_limit
	localparam int IDX_W   = 32;   // cell_index
	localparam int CFG_W   = 19;   // widest register
	localparam int ADDR_W  = 3;

	// cell arithmetic
	localparam int CELL_UM = 5000;       // cell size in micro-degrees
	localparam int CELL_MD = 5;          // cell size in thousandths
	localparam int Q_OFF   = 53688;      // bias on the cell number, keeps it positive
	localparam int U_OFF   = Q_OFF * CELL_UM;
	localparam int C_OFF   = Q_OFF * CELL_MD;

	localparam int U_W     = 30;         // biased coordinate
	localparam int Q_W     = 17;         // biased cell number
	localparam int R_W     = 14;         // remainder before correction (0..9999)
	localparam int C_W     = 20;         // corner, signed
	localparam int D_W     = 13;         // edge distance
	localparam int REL_W   = 21;         // corner minus origin, signed
	localparam int LIM_W   = 19;         // 5 * cells

	// floor(u / 5000) estimate: (u * RECIP_UM) >> RECIP_UM_SH, low by at most one
	localparam longint RECIP_UM    = 64'd879609302;
	localparam int     RECIP_UM_SH = 42;

	// x / 5 for x below 2^19: (x * RECIP_MD) >> RECIP_MD_SH, exact
	localparam int REL5_W      = 19;
	localparam int RECIP_MD_W  = 20;
	localparam int RECIP_MD    = 838861;
	localparam int RECIP_MD_SH = 22;

	localparam logic [BL_W-1:0] BORDER_RESET = BL_W'(1000);

	typedef enum logic [ADDR_W-1:0] {
		REG_LON_ORIGIN   = 3'd0,
		REG_LON_CELLS    = 3'd1,
		REG_LAT_ORIGIN   = 3'd2,
		REG_LAT_CELLS    = 3'd3,
		REG_BORDER_LIMIT = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		STEP_NONE = 2'd0,
		STEP_DOWN = 2'd1,
		STEP_UP   = 2'd2
	} step_t;

	typedef struct packed {
		logic signed [OLON_W-1:0]  lon_origin;
		logic        [CELLS_W-1:0] lon_cells;
		logic signed [OLAT_W-1:0]  lat_origin;
		logic        [CELLS_W-1:0] lat_cells;
		logic        [BL_W-1:0]    border_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [C_W-1:0] c;   // corner, thousandths
		logic        [D_W-1:0] d;   // distance to west/south edge, micro-degrees
	} axis_t;

	typedef struct packed {
		logic        [IDX_W-1:0] idx;
		logic signed [C_W-1:0]   clon;
		logic signed [C_W-1:0]   clat;
		logic [2:0]              lon_in;   // bit 0 minus side, 1 home, 2 plus side
		logic [2:0]              lat_in;
		logic                    w;
		logic                    e;
		logic                    s;
		logic                    n;
	} loc_t;

	typedef struct packed {
		logic                 status;
		logic [IDX_W-1:0]     index;
		logic [OLAT_W-1:0]    cell_lat;
		logic [OLON_W-1:0]    cell_lon;
	} res_t;

endpackage

FILE: sv/gni_floor.sv
// ----------------------------------------------------------------------------
// gni_floor
// Floors both coordinates to a cell: corner in thousandths, edge distance.
// ----------------------------------------------------------------------------
module gni_floor (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic signed [gni_pkg::LON_W-1:0]    lon_micro,
	input  logic signed [gni_pkg::LAT_W-1:0]    lat_micro,
	output logic                                out_valid,
	output gni_pkg::axis_t                      lon,
	output gni_pkg::axis_t                      lat
);
	localparam int UW = gni_pkg::U_W;
	localparam int QW = gni_pkg::Q_W;
	localparam int RW = gni_pkg::R_W;
	localparam int CW = gni_pkg::C_W;
	localparam int DW = gni_pkg::D_W;
	localparam int PW = 2 * UW;

	logic v_s1, v_s2, v_s3, v_s4;

	logic [UW-1:0] u_in  [2];
	logic [UW-1:0] u_s1  [2];
	logic [PW-1:0] prod  [2];
	logic [UW-1:0] u_s2  [2];
	logic [QW-1:0] qe_s2 [2];
	logic [UW-1:0] diff  [2];
	logic [RW-1:0] r_s3  [2];
	logic [QW-1:0] q_s3  [2];
	logic          ge    [2];
	logic [QW-1:0] qc    [2];
	logic [CW-1:0] q5    [2];
	logic [CW-1:0] c_nx  [2];
	logic [DW-1:0] d_nx  [2];
	logic [CW-1:0] c_s4  [2];
	logic [DW-1:0] d_s4  [2];

	// bias both lanes so the floor becomes an unsigned divide
	assign u_in[0] = UW'(lon_micro) + UW'(gni_pkg::U_OFF);
	assign u_in[1] = UW'(lat_micro) + UW'(gni_pkg::U_OFF);

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			prod[i] = PW'(u_s1[i]) * PW'(gni_pkg::RECIP_UM);
			diff[i] = u_s2[i] - UW'(qe_s2[i]) * UW'(gni_pkg::CELL_UM);
			ge[i]   = r_s3[i] >= RW'(gni_pkg::CELL_UM);
			qc[i]   = q_s3[i] + QW'(ge[i]);
			q5[i]   = CW'(qc[i]) * CW'(gni_pkg::CELL_MD);
			c_nx[i] = q5[i] - CW'(gni_pkg::C_OFF);
			d_nx[i] = ge[i] ? DW'(r_s3[i] - RW'(gni_pkg::CELL_UM)) : DW'(r_s3[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				u_s1[i]  <= u_in[i];
				u_s2[i]  <= u_s1[i];
				qe_s2[i] <= prod[i][gni_pkg::RECIP_UM_SH +: QW];
				q_s3[i]  <= qe_s2[i];
				r_s3[i]  <= diff[i][RW-1:0];
				c_s4[i]  <= c_nx[i];
				d_s4[i]  <= d_nx[i];
			end
		end
	end

	assign out_valid = v_s4;
	assign lon.c = $signed(c_s4[0]);
	assign lon.d = d_s4[0];
	assign lat.c = $signed(c_s4[1]);
	assign lat.d = d_s4[1];

endmodule

FILE: sv/gni_locate.sv
// ----------------------------------------------------------------------------
// gni_locate
// Places the cell in the grid: edge flags, neighbour membership, cell index.
// ----------------------------------------------------------------------------
module gni_locate (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  gni_pkg::cfg_t   cfg,
	input  logic            in_valid,
	input  gni_pkg::axis_t  lon,
	input  gni_pkg::axis_t  lat,
	output logic            out_valid,
	output gni_pkg::loc_t   loc
);
	localparam int RLW = gni_pkg::REL_W;
	localparam int LW  = gni_pkg::LIM_W;
	localparam int DW  = gni_pkg::D_W;
	localparam int CW  = gni_pkg::C_W;
	localparam int CLW = gni_pkg::CELLS_W;
	localparam int IW  = gni_pkg::IDX_W;
	localparam int MW  = gni_pkg::REL5_W + gni_pkg::RECIP_MD_W;

	function automatic logic in_span(logic signed [RLW-1:0] rel, logic signed [RLW:0] off,
			logic [LW-1:0] lim);
		logic signed [RLW:0] t;
		t = (RLW+1)'(rel) + off;
		return !t[RLW] && (t < $signed((RLW+1)'(lim)));
	endfunction

	logic v_s5, v_s6, v_s7;

	logic signed [RLW-1:0] rel_lon_s5, rel_lat_s5;
	logic signed [CW-1:0]  clon_s5, clat_s5, clon_s6, clat_s6, clon_s7, clat_s7;
	logic                  w_s5, e_s5, s_s5, n_s5, w_s6, e_s6, s_s6, n_s6;
	logic                  w_s7, e_s7, s_s7, n_s7;
	logic [DW-1:0]         lon_far, lat_far;

	logic [LW-1:0]         lim_lon, lim_lat;
	logic [MW-1:0]         pcol, prow;
	logic signed [RLW:0]   step;
	logic [2:0]            lon_in_s6, lat_in_s6, lon_in_s7, lat_in_s7;
	logic [CLW-1:0]        col_s6, row_s6;
	logic [IW-1:0]         idx_s7;

	assign lon_far = DW'(gni_pkg::CELL_UM) - lon.d;
	assign lat_far = DW'(gni_pkg::CELL_UM) - lat.d;

	assign lim_lon = LW'(cfg.lon_cells) * LW'(gni_pkg::CELL_MD);
	assign lim_lat = LW'(cfg.lat_cells) * LW'(gni_pkg::CELL_MD);
	assign step    = (RLW+1)'(gni_pkg::CELL_MD);

	// column and row are only used when the home cell is inside, so rel is small
	assign pcol = MW'(rel_lon_s5[gni_pkg::REL5_W-1:0]) * MW'(gni_pkg::RECIP_MD);
	assign prow = MW'(rel_lat_s5[gni_pkg::REL5_W-1:0]) * MW'(gni_pkg::RECIP_MD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s5 <= in_valid;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rel_lon_s5 <= RLW'($signed(lon.c)) - RLW'(cfg.lon_origin);
			rel_lat_s5 <= RLW'($signed(lat.c)) - RLW'(cfg.lat_origin);
			clon_s5    <= lon.c;
			clat_s5    <= lat.c;
			w_s5       <= lon.d < cfg.border_limit;
			e_s5       <= lon_far < cfg.border_limit;
			s_s5       <= lat.d < cfg.border_limit;
			n_s5       <= lat_far < cfg.border_limit;

			lon_in_s6  <= {in_span(rel_lon_s5, step, lim_lon),
				in_span(rel_lon_s5, '0, lim_lon),
				in_span(rel_lon_s5, -step, lim_lon)};
			lat_in_s6  <= {in_span(rel_lat_s5, step, lim_lat),
				in_span(rel_lat_s5, '0, lim_lat),
				in_span(rel_lat_s5, -step, lim_lat)};
			col_s6     <= pcol[gni_pkg::RECIP_MD_SH +: CLW];
			row_s6     <= prow[gni_pkg::RECIP_MD_SH +: CLW];
			clon_s6    <= clon_s5;
			clat_s6    <= clat_s5;
			w_s6       <= w_s5;
			e_s6       <= e_s5;
			s_s6       <= s_s5;
			n_s6       <= n_s5;

			idx_s7     <= IW'(row_s6) * IW'(cfg.lon_cells) + IW'(col_s6);
			lon_in_s7  <= lon_in_s6;
			lat_in_s7  <= lat_in_s6;
			clon_s7    <= clon_s6;
			clat_s7    <= clat_s6;
			w_s7       <= w_s6;
			e_s7       <= e_s6;
			s_s7       <= s_s6;
			n_s7       <= n_s6;
		end
	end

	assign out_valid  = v_s7;
	assign loc.idx    = idx_s7;
	assign loc.clon   = clon_s7;
	assign loc.clat   = clat_s7;
	assign loc.lon_in = lon_in_s7;
	assign loc.lat_in = lat_in_s7;
	assign loc.w      = w_s7;
	assign loc.e      = e_s7;
	assign loc.s      = s_s7;
	assign loc.n      = n_s7;

endmodule

FILE: sv/gni_emit.sv
// ----------------------------------------------------------------------------
// gni_emit
// Picks the cells to report for one position and sends them one beat each.
// ----------------------------------------------------------------------------
module gni_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [gni_pkg::CELLS_W-1:0] lon_cells,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  gni_pkg::loc_t        loc,
	output logic                 out_valid,
	input  logic                 out_ready,
	output gni_pkg::res_t        out_res,
	output logic                 out_last
);
	localparam int CW  = gni_pkg::C_W;
	localparam int IW  = gni_pkg::IDX_W;
	localparam int CLW = gni_pkg::CELLS_W;

	function automatic gni_pkg::res_t make_cell(logic signed [CW-1:0] clon,
			logic signed [CW-1:0] clat, logic [IW-1:0] idx, logic [CLW-1:0] cols,
			gni_pkg::step_t dx, gni_pkg::step_t dy);
		gni_pkg::res_t r;
		logic signed [CW-1:0] x, y;
		logic [IW-1:0] ix;
		x  = clon;
		y  = clat;
		ix = idx;
		case (dx)
			gni_pkg::STEP_DOWN: begin
				x  = clon - CW'(gni_pkg::CELL_MD);
				ix = ix - IW'(1);
			end
			gni_pkg::STEP_UP: begin
				x  = clon + CW'(gni_pkg::CELL_MD);
				ix = ix + IW'(1);
			end
			default: ;
		endcase
		case (dy)
			gni_pkg::STEP_DOWN: begin
				y  = clat - CW'(gni_pkg::CELL_MD);
				ix = ix - IW'(cols);
			end
			gni_pkg::STEP_UP: begin
				y  = clat + CW'(gni_pkg::CELL_MD);
				ix = ix + IW'(cols);
			end
			default: ;
		endcase
		r.status   = 1'b0;
		r.index    = ix;
		r.cell_lat = y[gni_pkg::OLAT_W-1:0];
		r.cell_lon = x[gni_pkg::OLON_W-1:0];
		return r;
	endfunction

	gni_pkg::res_t cand [4];
	logic          ok   [4];
	gni_pkg::res_t list [4];
	logic [2:0]    n_nx;

	gni_pkg::res_t ent_q [4];
	logic [2:0]    cnt_q;

	gni_pkg::step_t hx, vy, ddx, ddy;
	logic           h_ok, v_ok, d_ok, home_in;
	logic           load, beat;

	always_comb begin
		home_in = loc.lon_in[1] && loc.lat_in[1];

		hx   = gni_pkg::STEP_NONE;
		h_ok = 1'b0;
		if (loc.w) begin
			hx   = gni_pkg::STEP_DOWN;
			h_ok = loc.lon_in[0];
		end else if (loc.e) begin
			hx   = gni_pkg::STEP_UP;
			h_ok = loc.lon_in[2];
		end

		vy   = gni_pkg::STEP_NONE;
		v_ok = 1'b0;
		if (loc.s) begin
			vy   = gni_pkg::STEP_DOWN;
			v_ok = loc.lat_in[0];
		end else if (loc.n) begin
			vy   = gni_pkg::STEP_UP;
			v_ok = loc.lat_in[2];
		end

		ddx  = gni_pkg::STEP_NONE;
		ddy  = gni_pkg::STEP_NONE;
		d_ok = 1'b0;
		if (loc.w && loc.s) begin
			ddx  = gni_pkg::STEP_DOWN;
			ddy  = gni_pkg::STEP_DOWN;
			d_ok = loc.lon_in[0] && loc.lat_in[0];
		end else if (loc.w && loc.n) begin
			ddx  = gni_pkg::STEP_DOWN;
			ddy  = gni_pkg::STEP_UP;
			d_ok = loc.lon_in[0] && loc.lat_in[2];
		end else if (loc.e && loc.s) begin
			ddx  = gni_pkg::STEP_UP;
			ddy  = gni_pkg::STEP_DOWN;
			d_ok = loc.lon_in[2] && loc.lat_in[0];
		end else if (loc.e && loc.n) begin
			ddx  = gni_pkg::STEP_UP;
			ddy  = gni_pkg::STEP_UP;
			d_ok = loc.lon_in[2] && loc.lat_in[2];
		end

		cand[0] = make_cell(loc.clon, loc.clat, loc.idx, lon_cells,
			gni_pkg::STEP_NONE, gni_pkg::STEP_NONE);
		cand[1] = make_cell(loc.clon, loc.clat, loc.idx, lon_cells, hx, gni_pkg::STEP_NONE);
		cand[2] = make_cell(loc.clon, loc.clat, loc.idx, lon_cells, gni_pkg::STEP_NONE, vy);
		cand[3] = make_cell(loc.clon, loc.clat, loc.idx, lon_cells, ddx, ddy);
		ok[0]   = 1'b1;
		ok[1]   = home_in && h_ok;
		ok[2]   = home_in && v_ok;
		ok[3]   = home_in && d_ok;

		// outside the grid: a single status beat with zero payload
		if (!home_in) begin
			cand[0]        = '0;
			cand[0].status = 1'b1;
		end

		for (int i = 0; i < 4; i++)
			list[i] = '0;
		n_nx = '0;
		for (int i = 0; i < 4; i++) begin
			if (ok[i]) begin
				list[n_nx[1:0]] = cand[i];
				n_nx            = n_nx + 3'd1;
			end
		end
	end

	assign out_valid = cnt_q != 3'd0;
	assign out_last  = cnt_q == 3'd1;
	assign out_res   = ent_q[0];
	assign beat      = out_valid && out_ready;
	assign in_ready  = (cnt_q == 3'd0) || (out_last && out_ready);
	assign load      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= n_nx;
		end else if (beat) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < 4; i++)
				ent_q[i] <= list[i];
		end else if (beat) begin
			for (int i = 0; i < 3; i++)
				ent_q[i] <= ent_q[i+1];
		end
	end

endmodule

FILE: sv/gps_grid_neighbour_indexer.sv
// ----------------------------------------------------------------------------
// gps_grid_neighbour_indexer
// Maps a GPS position to its 0.005-degree grid cell and nearby neighbours.
// ----------------------------------------------------------------------------
// Input stream: one beat per position, longitude and latitude in micro-degrees.
// Output stream: one beat per reported cell, tlast on the final cell of a
// position. A position inside the grid yields its home cell and, near a cell
// edge, up to one horizontal, one vertical and one diagonal neighbour that are
// inside the grid. A position outside the grid yields one beat with tuser set.
// Pipeline: a position passes seven pipeline stages plus the output register
// before its first result beat is valid. Throughput: a position with n result
// cells (1 to 4) occupies the output for n beats; the single output channel
// sets the rate, the pipeline takes one position per cycle otherwise.
// Configuration: write the grid registers through cfg_we/cfg_addr/cfg_data
// while no position is in flight. Reset empties the pipeline, clears the grid
// to zero size (every position reports out of range) and sets the border limit
// to 1000 micro-degrees. When the receiver stalls, the pipeline holds in place
// and s_axis_tready drops once the last stage is full.
// ----------------------------------------------------------------------------
module gps_grid_neighbour_indexer (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        cfg_we,
	input  logic [gni_pkg::ADDR_W-1:0]  cfg_addr,
	input  logic [gni_pkg::CFG_W-1:0]   cfg_data,

	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [63:0]                 s_axis_tdata,   // lon_micro[28:0], lat_micro[56:29]

	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [71:0]                 m_axis_tdata,   // cell_lon[18:0], cell_lat[36:19],
	                                                    // cell_index[68:37]
	output logic                        m_axis_tuser,   // status
	output logic                        m_axis_tlast
);
	gni_pkg::cfg_t  cfg_q;
	gni_pkg::axis_t lon, lat;
	gni_pkg::loc_t  loc;
	gni_pkg::res_t  res;
	logic           fl_valid, loc_valid, emit_ready, en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lon_origin   <= '0;
			cfg_q.lon_cells    <= '0;
			cfg_q.lat_origin   <= '0;
			cfg_q.lat_cells    <= '0;
			cfg_q.border_limit <= gni_pkg::BORDER_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				gni_pkg::REG_LON_ORIGIN:   cfg_q.lon_origin   <= $signed(cfg_data[gni_pkg::OLON_W-1:0]);
				gni_pkg::REG_LON_CELLS:    cfg_q.lon_cells    <= cfg_data[gni_pkg::CELLS_W-1:0];
				gni_pkg::REG_LAT_ORIGIN:   cfg_q.lat_origin   <= $signed(cfg_data[gni_pkg::OLAT_W-1:0]);
				gni_pkg::REG_LAT_CELLS:    cfg_q.lat_cells    <= cfg_data[gni_pkg::CELLS_W-1:0];
				gni_pkg::REG_BORDER_LIMIT: cfg_q.border_limit <= cfg_data[gni_pkg::BL_W-1:0];
				default: ;
			endcase
		end
	end

	// advance the whole pipeline unless its last stage is blocked
	assign en            = !loc_valid || emit_ready;
	assign s_axis_tready = en;

	gni_floor u_floor (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.lon_micro ($signed(s_axis_tdata[gni_pkg::LON_W-1:0])),
		.lat_micro ($signed(s_axis_tdata[gni_pkg::LON_W +: gni_pkg::LAT_W])),
		.out_valid (fl_valid),
		.lon       (lon),
		.lat       (lat)
	);

	gni_locate u_locate (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg_q),
		.in_valid  (fl_valid),
		.lon       (lon),
		.lat       (lat),
		.out_valid (loc_valid),
		.loc       (loc)
	);

	gni_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.lon_cells (cfg_q.lon_cells),
		.in_valid  (loc_valid),
		.in_ready  (emit_ready),
		.loc       (loc),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {3'b000, res.index, res.cell_lat, res.cell_lon};
	assign m_axis_tuser = res.status;

endmodule
